// ----- rtl/core/pbwd_pkg.sv -----
// ----------------------------------------------------------------------------
// pbwd_pkg
// Shared types and constants for the windowed PackBits decoder: register
// indexes, header codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package pbwd_pkg;

    // configuration port
    localparam int CFG_W = 32;
    localparam logic [0:0] REG_RANGE_START = 1'd0;
    localparam logic [0:0] REG_RANGE_END   = 1'd1;

    // header decode
    localparam logic [7:0] HDR_LIT_MAX = 8'd127;  // 0..127: literal run of header+1
    localparam logic [7:0] HDR_SKIP    = 8'h80;   // -128: no-op header
    localparam logic [8:0] RUN_BASE    = 9'd257;  // run length = 257 - header

    // byte counts carried by a result
    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_LITERAL,
        ST_RUNVAL,
        ST_EXPAND,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_hdr;
        logic take_lit;
        logic load_val;
        logic exp_step;
        logic flush_push;
        logic clr_pos;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hdr_lit;
        logic hdr_run;
        logic lit_last;
        logic end_hit;
        logic exp_last;
        logic exp_stall;
        logic stg_v;
        logic out_free;
        logic eop_held;
        logic stopped;
    } t_status;

endpackage

// ----- rtl/core/pbwd_in_if.sv -----
// ----------------------------------------------------------------------------
// pbwd_in_if
// Compressed byte channel: valid/ready with one code byte and packet end flag.
// ----------------------------------------------------------------------------
interface pbwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       end_of_packet;

    modport source (output valid, code_byte, end_of_packet, input ready);
    modport sink   (input valid, code_byte, end_of_packet, output ready);
endinterface

// ----- rtl/core/pbwd_out_if.sv -----
// ----------------------------------------------------------------------------
// pbwd_out_if
// Decoded byte channel: valid/ready with one or two bytes per request.
// ----------------------------------------------------------------------------
interface pbwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [1:0] byte_count;
    logic       last_of_item;

    modport source (output valid, byte_first, byte_second, byte_count, last_of_item,
                    input ready);
    modport sink   (input valid, byte_first, byte_second, byte_count, last_of_item,
                    output ready);
endinterface

// ----- rtl/core/packbits_windowed_decoder.sv -----
// ----------------------------------------------------------------------------
// packbits_windowed_decoder
// PackBits stream decoder that emits only the decoded bytes whose position
// within the packet lies in [range_start, range_end).
// ----------------------------------------------------------------------------
// Header, literal and run value bytes are taken one per cycle; a literal byte
// waits only while the output register holds an untaken request. A run value
// byte then holds the input while the expander walks the decoded positions of
// the run (up to 128, fewer when range_end is reached), one position per
// cycle unless stalled, and then hands over the final request. A step that
// completes a request also waits while the staging and output registers both
// hold untaken requests, and the handover waits for the output register.
// Run bytes leave two to a request through a one-deep staging register, so a
// run of N in-window copies takes (N + 1) / 2 output requests.
// Positions saturate at the top of the POSITION_WIDTH counter and restart at
// zero after the byte that carries end_of_packet. The user must write
// range_start and range_end through the config port while the block is idle;
// the block itself does not enforce this.
module packbits_windowed_decoder import pbwd_pkg::*; #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    pbwd_in_if.sink          i_in,
    pbwd_out_if.source       o_out
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    // phase controller
    pbwd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .i_end_of_packet (i_in.end_of_packet),
        .i_status        (w_status),
        .o_in_ready      (w_in_ready),
        .o_cmd           (w_cmd)
    );

    // position, window and result registers
    pbwd_dp #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_code_byte     (i_in.code_byte),
        .i_end_of_packet (i_in.end_of_packet),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_byte_first    (o_out.byte_first),
        .o_byte_second   (o_out.byte_second),
        .o_byte_count    (o_out.byte_count),
        .o_last_of_item  (o_out.last_of_item)
    );

    assign i_in.ready = w_in_ready;

endmodule

// ----- rtl/core/pbwd_dp.sv -----
// ----------------------------------------------------------------------------
// pbwd_dp
// Datapath: window registers, position counter, run bookkeeping, a one-deep
// staging register for run results and the output register.
// ----------------------------------------------------------------------------
module pbwd_dp import pbwd_pkg::*; #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic [7:0]       i_code_byte,
    input  logic             i_end_of_packet,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_byte_first,
    output logic [7:0]       o_byte_second,
    output logic [1:0]       o_byte_count,
    output logic             o_last_of_item
);

    localparam int CMP_W = (POSITION_WIDTH > CFG_W) ? POSITION_WIDTH : CFG_W;
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    // control state
    logic [CFG_W-1:0]          r_range_start, r_range_end;
    logic [POSITION_WIDTH-1:0] r_pos, n_pos;
    logic [7:0]                r_bl, n_bl;
    logic                      r_pend, n_pend;
    logic                      r_stg_v, n_stg_v;
    logic                      r_out_v, n_out_v;
    logic                      r_stopped, n_stopped;
    logic                      r_eop, n_eop;

    // payload
    logic [7:0] r_val;
    logic [7:0] r_stg_first, r_stg_second;
    logic [1:0] r_stg_count;
    logic [7:0] r_out_first, r_out_second;
    logic [1:0] r_out_count;
    logic       r_out_last;

    logic [POSITION_WIDTH-1:0] w_pos_inc;
    logic [CMP_W-1:0]          w_pos_x, w_inc_x, w_start_x, w_end_x;
    logic                      w_in_win, w_end_hit, w_exp_last;
    logic                      w_pair, w_produce, w_out_free;
    logic                      w_out_wr, w_stg_wr;
    logic [7:0]                w_out_first, w_out_second;
    logic [1:0]                w_out_count;
    logic                      w_out_last;

    // window test on the current position, saturating increment
    always_comb begin
        w_pos_inc  = (r_pos == POS_MAX) ? r_pos : r_pos + POSITION_WIDTH'(1);
        w_pos_x    = CMP_W'(r_pos);
        w_inc_x    = CMP_W'(w_pos_inc);
        w_start_x  = CMP_W'(r_range_start);
        w_end_x    = CMP_W'(r_range_end);
        w_in_win   = (w_pos_x >= w_start_x) && (w_pos_x < w_end_x);
        w_end_hit  = w_inc_x >= w_end_x;
        w_exp_last = (r_bl == 8'd1) || w_end_hit;
        w_pair     = w_in_win && r_pend;
        w_produce  = w_pair || (w_exp_last && (r_pend ^ w_in_win));
        w_out_free = !r_out_v || i_out_ready;
    end

    // status to controller
    always_comb begin
        o_status.hdr_lit   = i_code_byte <= HDR_LIT_MAX;
        o_status.hdr_run   = i_code_byte > HDR_SKIP;
        o_status.lit_last  = r_bl == 8'd1;
        o_status.end_hit   = w_end_hit;
        o_status.exp_last  = w_exp_last;
        o_status.exp_stall = w_produce && r_stg_v && !w_out_free;
        o_status.stg_v     = r_stg_v;
        o_status.out_free  = w_out_free;
        o_status.eop_held  = r_eop;
        o_status.stopped   = r_stopped;
    end

    // next state of the datapath registers
    always_comb begin
        n_pos        = r_pos;
        n_bl         = r_bl;
        n_pend       = r_pend;
        n_stg_v      = r_stg_v;
        n_out_v      = r_out_v && !i_out_ready;
        n_stopped    = r_stopped;
        n_eop        = r_eop;
        w_out_wr     = 1'b0;
        w_stg_wr     = 1'b0;
        w_out_first  = r_stg_first;
        w_out_second = r_stg_second;
        w_out_count  = r_stg_count;
        w_out_last   = 1'b0;

        // header: load run length
        if (i_cmd.load_hdr) begin
            if (o_status.hdr_lit) begin
                n_bl = i_code_byte + 8'd1;
            end else if (o_status.hdr_run) begin
                n_bl = 8'(RUN_BASE - {1'b0, i_code_byte});
            end
        end

        // literal byte: one position, at most one result
        if (i_cmd.take_lit) begin
            n_pos = w_pos_inc;
            n_bl  = r_bl - 8'd1;
            if (w_in_win) begin
                w_out_wr     = 1'b1;
                w_out_first  = i_code_byte;
                w_out_second = 8'd0;
                w_out_count  = CNT_ONE;
                w_out_last   = 1'b1;
            end
        end

        if (i_cmd.load_val) begin
            n_eop = i_end_of_packet;
        end

        // run expansion: one position per step, previous staged result moves out when a new one is made
        if (i_cmd.exp_step) begin
            n_pos  = w_pos_inc;
            n_bl   = w_exp_last ? 8'd0 : r_bl - 8'd1;
            n_pend = w_exp_last ? 1'b0 : (r_pend ^ w_in_win);
            if (w_exp_last) begin
                n_stopped = w_end_hit;
            end
            if (w_produce) begin
                w_stg_wr = 1'b1;
                n_stg_v  = 1'b1;
                if (r_stg_v) begin
                    w_out_wr = 1'b1;
                end
            end
        end

        // final staged result of a run carries the last flag
        if (i_cmd.flush_push) begin
            w_out_wr   = 1'b1;
            w_out_last = 1'b1;
            n_stg_v    = 1'b0;
        end

        // end of packet
        if (i_cmd.clr_pos) begin
            n_pos = '0;
            n_bl  = 8'd0;
        end

        if (w_out_wr) begin
            n_out_v = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= '0;
            r_range_end   <= '1;
            r_pos         <= '0;
            r_bl          <= 8'd0;
            r_pend        <= 1'b0;
            r_stg_v       <= 1'b0;
            r_out_v       <= 1'b0;
            r_stopped     <= 1'b0;
            r_eop         <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_RANGE_START) begin
                r_range_start <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_RANGE_END) begin
                r_range_end <= i_cfg_data;
            end
            r_pos     <= n_pos;
            r_bl      <= n_bl;
            r_pend    <= n_pend;
            r_stg_v   <= n_stg_v;
            r_out_v   <= n_out_v;
            r_stopped <= n_stopped;
            r_eop     <= n_eop;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_val) begin
            r_val <= i_code_byte;
        end
        if (w_stg_wr) begin
            r_stg_first  <= r_val;
            r_stg_second <= w_pair ? r_val : 8'd0;
            r_stg_count  <= w_pair ? CNT_TWO : CNT_ONE;
        end
        if (w_out_wr) begin
            r_out_first  <= w_out_first;
            r_out_second <= w_out_second;
            r_out_count  <= w_out_count;
            r_out_last   <= w_out_last;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_byte_first   = r_out_first;
    assign o_byte_second  = r_out_second;
    assign o_byte_count   = r_out_count;
    assign o_last_of_item = r_out_last;

    // checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_wr |-> w_out_free)
        else $error("output register written while holding a result");

    a_flush_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush_push |-> r_stg_v)
        else $error("flush without a staged result");

    a_pend_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exp_step && w_exp_last) |=> (!r_pend && r_bl == 8'd0))
        else $error("run state not cleared after last step");

endmodule

// ----- rtl/core/pbwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbwd_ctrl
// Controller: tracks the decode phase, drives input ready and issues the
// per-cycle commands to the datapath.
// ----------------------------------------------------------------------------
module pbwd_ctrl import pbwd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_end_of_packet,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   w_acc;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_acc      = 1'b0;

        unique case (r_state)
            ST_HEADER: begin
                o_in_ready = 1'b1;
                w_acc      = i_in_valid;
                if (w_acc) begin
                    o_cmd.load_hdr = 1'b1;
                    if (i_end_of_packet) begin
                        o_cmd.clr_pos = 1'b1;
                    end else if (i_status.hdr_lit) begin
                        n_state = ST_LITERAL;
                    end else if (i_status.hdr_run) begin
                        n_state = ST_RUNVAL;
                    end
                end
            end
            ST_LITERAL: begin
                o_in_ready = i_status.out_free;
                w_acc      = i_in_valid && i_status.out_free;
                if (w_acc) begin
                    o_cmd.take_lit = 1'b1;
                    if (i_end_of_packet) begin
                        o_cmd.clr_pos = 1'b1;
                        n_state       = ST_HEADER;
                    end else if (i_status.end_hit) begin
                        n_state = ST_DONE;
                    end else if (i_status.lit_last) begin
                        n_state = ST_HEADER;
                    end
                end
            end
            ST_RUNVAL: begin
                o_in_ready = 1'b1;
                w_acc      = i_in_valid;
                if (w_acc) begin
                    o_cmd.load_val = 1'b1;
                    n_state        = ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (!i_status.exp_stall) begin
                    o_cmd.exp_step = 1'b1;
                    if (i_status.exp_last) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_status.stg_v || i_status.out_free) begin
                    o_cmd.flush_push = i_status.stg_v;
                    if (i_status.eop_held) begin
                        o_cmd.clr_pos = 1'b1;
                        n_state       = ST_HEADER;
                    end else begin
                        n_state = i_status.stopped ? ST_DONE : ST_HEADER;
                    end
                end
            end
            ST_DONE: begin
                o_in_ready = 1'b1;
                w_acc      = i_in_valid;
                if (w_acc && i_end_of_packet) begin
                    o_cmd.clr_pos = 1'b1;
                    n_state       = ST_HEADER;
                end
            end
            default: begin
                n_state = ST_HEADER;
            end
        endcase
    end

    // checks
    a_lit_no_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LITERAL || r_state == ST_HEADER) |-> !i_status.stg_v)
        else $error("staged run result left behind");

    a_flush_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exp_step && i_status.exp_last) |=> (r_state == ST_FLUSH))
        else $error("last run step did not enter flush");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPAND || r_state == ST_FLUSH) |-> !o_in_ready)
        else $error("input taken during run expansion");

endmodule

// ----- sim/packbits_windowed_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packbits_windowed_decoder_test
// Drives PackBits packets into the windowed decoder, runs a software copy of
// the decoder next to it and compares every decoded request in order. Covers
// literal and run expansion, skip headers, packet cuts, window edges and
// output back-pressure, then a long stretch of random packets.
// ----------------------------------------------------------------------------
module packbits_windowed_decoder_test;
    import pbwd_pkg::*;

    localparam int          POS_W          = 32;
    localparam logic [31:0] POS_TOP        = 32'hFFFF_FFFF;
    localparam int          HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int          SETTLE_CYCLES  = 140;   // a full run walk plus handover
    localparam int          DRAIN_CYCLES   = 150;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SHOWN_ERRORS   = 10;

    // decoder phase as the block tracks it
    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_LITERAL,
        DEC_RUN,
        DEC_DONE
    } t_dec_phase;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] count;
        logic       last;
    } t_decoded;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    pbwd_in_if  code_chan ();
    pbwd_out_if byte_chan ();

    packbits_windowed_decoder #(
        .POSITION_WIDTH(POS_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (code_chan),
        .o_out     (byte_chan)
    );

    // decoder copy: window registers and packet state
    logic [31:0] win_first;
    logic [31:0] win_end;
    t_dec_phase  dec_phase;
    logic [7:0]  dec_owed;
    logic [31:0] dec_pos;

    t_decoded    decoded_due[$];
    int unsigned decoded_seen;
    int unsigned live_items;
    int unsigned mismatches;
    int unsigned stray_results;

    // sender and receiver pacing
    int unsigned burst_left;
    bit          sender_steady;
    bit          hold_off_armed;
    int unsigned pkt_left;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // decoder copy
    // ------------------------------------------------------------------------

    // counts one decoded byte, returns whether it falls in the window
    function automatic bit take_pos();
        bit hit;
        hit = (dec_pos >= win_first) && (dec_pos < win_end);
        if (dec_pos != POS_TOP)
            dec_pos = dec_pos + 32'd1;
        return hit;
    endfunction

    task automatic decode_code_byte(input logic [7:0] code, input logic eop);
        int unsigned copies;
        int unsigned k;
        bit          stopped;
        copies  = 0;
        stopped = 1'b0;
        live_items++;
        case (dec_phase)
            DEC_HEADER: begin
                if (code <= HDR_LIT_MAX) begin
                    dec_phase = DEC_LITERAL;
                    dec_owed  = code + 8'd1;
                end else if (code != HDR_SKIP) begin
                    dec_phase = DEC_RUN;
                    dec_owed  = 8'(RUN_BASE - code);
                end
            end
            DEC_LITERAL: begin
                if (take_pos())
                    decoded_due.push_back('{first: code, second: 8'd0, count: CNT_ONE,
                                           last: 1'b1});
                if (dec_owed != 8'd0)
                    dec_owed--;
                if (dec_pos >= win_end)
                    dec_phase = DEC_DONE;
                else if (dec_owed == 8'd0)
                    dec_phase = DEC_HEADER;
            end
            DEC_RUN: begin
                // walk the run, then emit the in-window copies as pairs, an odd last one alone
                while (dec_owed != 8'd0) begin
                    if (take_pos())
                        copies++;
                    dec_owed--;
                    if (dec_pos >= win_end) begin
                        stopped = 1'b1;
                        break;
                    end
                end
                for (k = 0; k < copies / 2; k++)
                    decoded_due.push_back('{first: code, second: code, count: CNT_TWO,
                                           last: (copies == 2 * k + 2)});
                if (copies % 2 == 1)
                    decoded_due.push_back('{first: code, second: 8'd0, count: CNT_ONE,
                                           last: 1'b1});
                dec_owed  = 8'd0;
                dec_phase = stopped ? DEC_DONE : DEC_HEADER;
            end
            default: ;
        endcase
        if (eop) begin
            dec_phase = DEC_HEADER;
            dec_owed  = 8'd0;
            dec_pos   = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------------

    // offers one code byte, bursts separated by random gaps unless sender_steady
    task automatic send_code(input logic [7:0] code, input logic eop);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = sender_steady ? 0 :
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                code_chan.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        code_chan.valid         <= 1'b1;
        code_chan.code_byte     <= code;
        code_chan.end_of_packet <= eop;
        @(posedge i_clk);
        while (!code_chan.ready) @(posedge i_clk);
        decode_code_byte(code, eop);
    endtask

    // drains every expected request, then lets a pending run walk finish
    task automatic wait_idle();
        code_chan.valid <= 1'b0;
        burst_left = 0;
        while (decoded_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [31:0] first_pos, input logic [31:0] end_pos);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_RANGE_START;
        cfg_data <= first_pos;
        @(posedge i_clk);
        cfg_idx  <= REG_RANGE_END;
        cfg_data <= end_pos;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        win_first = first_pos;
        win_end   = end_pos;
    endtask

    // byte of a generated packet; the last one carries end of packet
    task automatic put_packet_byte(input logic [7:0] b);
        send_code(b, pkt_left == 1);
        pkt_left--;
    endtask

    // well-formed chunks with random content, possibly cut by end of packet
    task automatic send_random_packet();
        int unsigned len;
        int unsigned k;
        logic [7:0]  hdr;
        pkt_left = $urandom_range(3, 40);
        while (pkt_left > 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    hdr = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 127)) :
                                                        8'($urandom_range(0, 7));
                    put_packet_byte(hdr);
                    for (k = 0; k <= hdr && pkt_left > 0; k++)
                        put_packet_byte(8'($urandom));
                end
                9: put_packet_byte(HDR_SKIP);
                default: begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 128) :
                                                        $urandom_range(2, 10);
                    put_packet_byte(8'(RUN_BASE - 9'(len)));
                    if (pkt_left > 0)
                        put_packet_byte(8'($urandom));
                end
            endcase
        end
    endtask

    // arbitrary bytes, closed by an end of packet to resync
    task automatic send_noise();
        int unsigned n;
        int unsigned k;
        n = $urandom_range(1, 8);
        for (k = 1; k <= n; k++)
            send_code(8'($urandom), (k == n) || ($urandom_range(0, 3) == 0));
    endtask

    task automatic run_random_phase(input logic [31:0] first_pos, input logic [31:0] end_pos,
                                    input int unsigned item_goal,
                                    input int unsigned result_goal);
        int unsigned live_mark;
        int unsigned seen_mark;
        int unsigned sent_mark;
        write_window(first_pos, end_pos);
        live_mark = live_items;
        seen_mark = decoded_seen;
        sent_mark = 0;
        while ((live_items - live_mark < item_goal || decoded_seen - seen_mark < result_goal)
               && sent_mark < item_goal * 8) begin
            if ($urandom_range(0, 9) < 8)
                send_random_packet();
            else
                send_noise();
            sent_mark++;
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_literal_runs();
        send_code(8'h00, 1'b0);
        send_code(8'hFF, 1'b0);
        send_code(8'h01, 1'b0);
        send_code(8'h00, 1'b0);
        send_code(8'hA5, 1'b0);
        send_code(HDR_SKIP, 1'b0);
        send_code(HDR_LIT_MAX, 1'b0);
        send_code(8'h5A, 1'b1);     // long literal cut by end of packet
    endtask

    task automatic test_run_expansion();
        send_code(8'hFF, 1'b0);     // shortest run, one pair
        send_code(8'h00, 1'b0);
        send_code(8'h81, 1'b0);     // longest run, 64 pairs
        send_code(8'hFF, 1'b0);
        send_code(8'hFE, 1'b0);     // odd run ends on a single
        send_code(8'h3C, 1'b1);
    endtask

    task automatic test_packet_cut();
        send_code(8'h83, 1'b1);     // run header dropped with the packet
        send_code(HDR_SKIP, 1'b1);
    endtask

    task automatic test_window_edges();
        write_window(32'd3, 32'd6);
        send_code(8'h03, 1'b0);
        send_code(8'h11, 1'b0);
        send_code(8'h22, 1'b0);
        send_code(8'h33, 1'b0);
        send_code(8'h44, 1'b0);
        send_code(8'hFB, 1'b0);     // run crosses the window end and stops
        send_code(8'h77, 1'b0);
        send_code(8'h12, 1'b0);     // ignored once done
        send_code(8'hC4, 1'b1);
    endtask

    task automatic test_empty_window();
        write_window(32'd0, 32'd0);
        send_code(8'h00, 1'b0);
        send_code(8'h99, 1'b0);
        send_code(8'h07, 1'b1);
        write_window(POS_TOP, POS_TOP);
        send_code(8'hFD, 1'b0);
        send_code(8'h42, 1'b1);
    endtask

    task automatic test_backpressure();
        write_window(32'd0, POS_TOP);
        sender_steady  = 1'b1;
        hold_off_armed = 1'b1;
        send_code(8'h81, 1'b0);
        send_code(8'h6E, 1'b0);
        send_code(8'h09, 1'b0);
        repeat (10) send_code(8'($urandom), 1'b0);
        send_code(8'hF0, 1'b0);
        send_code(8'hB3, 1'b1);
        sender_steady = 1'b0;
    endtask

    task automatic test_random_streams();
        int unsigned s;
        s = $urandom_range(0, 30);
        run_random_phase(32'd0, POS_TOP, 30, 12);
        run_random_phase(s, s + $urandom_range(1, 40), 20, 4);
        run_random_phase(32'd20 + $urandom_range(0, 10), $urandom_range(1, 19), 12, 0);
        run_random_phase(32'd0, $urandom_range(1, 20), 18, 0);
        run_random_phase(32'd0, POS_TOP, 18, 8);
    endtask

    // ------------------------------------------------------------------------
    // receiver: stall patterns plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        t_rx_mode    mode;
        int unsigned span;
        int unsigned hold_left;
        mode      = RX_OPEN;
        span      = 0;
        hold_left = 0;
        byte_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                byte_chan.ready <= 1'b0;
            end else if (hold_off_armed) begin
                hold_off_armed = 1'b0;
                hold_left = HOLD_CYCLES;
                byte_chan.ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    span = $urandom_range(16, 96);
                end
                span--;
                case (mode)
                    RX_OPEN:     byte_chan.ready <= 1'b1;
                    RX_COIN:     byte_chan.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: byte_chan.ready <= (span % 4) != 0;
                    default:     byte_chan.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check against the oldest expected request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_decoded got;
        t_decoded want;
        if (i_rst_n && byte_chan.valid && byte_chan.ready) begin
            got = {byte_chan.byte_first, byte_chan.byte_second, byte_chan.byte_count,
                   byte_chan.last_of_item};
            decoded_seen++;
            if (decoded_due.size() == 0) begin
                stray_results++;
                if (mismatches + stray_results <= SHOWN_ERRORS)
                    $display("unexpected request: first %h second %h count %0d last %b",
                             got.first, got.second, got.count, got.last);
            end else begin
                want = decoded_due.pop_front();
                if (got.first !== want.first || got.second !== want.second ||
                    got.count !== want.count || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches + stray_results <= SHOWN_ERRORS)
                        $display({"mismatch: expected first %h second %h count %0d last %b,",
                                  " got first %h second %h count %0d last %b"},
                                 want.first, want.second, want.count, want.last,
                                 got.first, got.second, got.count, got.last);
                end
            end
        end
    end

    // watchdog: too long without any request moving on either side
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((code_chan.valid && code_chan.ready) || (byte_chan.valid && byte_chan.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("packbits_windowed_decoder_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        win_first      = 32'd0;
        win_end        = POS_TOP;
        dec_phase      = DEC_HEADER;
        dec_owed       = 8'd0;
        dec_pos        = '0;
        decoded_seen   = 0;
        live_items     = 0;
        mismatches     = 0;
        stray_results  = 0;
        burst_left     = 0;
        sender_steady  = 1'b0;
        hold_off_armed = 1'b0;
        pkt_left       = 0;

        i_rst_n                 <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_idx                 <= REG_RANGE_START;
        cfg_data                <= '0;
        code_chan.valid         <= 1'b0;
        code_chan.code_byte     <= 8'd0;
        code_chan.end_of_packet <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_literal_runs();
        test_run_expansion();
        test_packet_cut();
        test_window_edges();
        test_empty_window();
        test_backpressure();
        test_random_streams();

        code_chan.valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && stray_results == 0 && decoded_due.size() == 0)
            $display("packbits_windowed_decoder_test: done, clean");
        else
            $display("packbits_windowed_decoder_test: done, errors");
        $finish;
    end

endmodule
